// File: rtl/core/eabv_pkg.sv
// Shared types, constants and the Q30 multiply used by the Euler-angle basis pipeline.
// Depends on nothing; every other file in rtl/core but eabv_checker imports it.
`timescale 1ns / 1ps

package eabv_pkg;

    localparam int ANGLE_W     = 16;
    localparam int SINE_STAGES = 11;
    localparam int OUT_STAGES  = 2;
    localparam int PIPE_STAGES = SINE_STAGES + OUT_STAGES;

    localparam int Q_FRAC     = 30;
    localparam int SINE_MAG_W = 31;

    // Degrees-to-radians factor pi/180 in Q0.40, split into two partial products.
    localparam int D2R_W    = 35;
    localparam int D2R_LO_W = 17;
    localparam int D2R_HI_W = D2R_W - D2R_LO_W;
    localparam logic [D2R_W-1:0] D2R_Q40 = 35'd19190098069;

    localparam logic [31:0] COEF3_Q30 = 32'd178956971;
    localparam logic [31:0] COEF5_Q30 = 32'd8947849;
    localparam logic [31:0] COEF7_Q30 = 32'd213044;
    localparam logic [31:0] ONE_Q30   = 32'd1073741824;
    localparam logic [63:0] Q30_HALF  = 64'h0000_0000_2000_0000;

    typedef struct packed {
        logic                  neg;
        logic [SINE_MAG_W-1:0] mag;
    } sine_t;

    function automatic logic [33:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + Q30_HALF;
        return p[63:30];
    endfunction

endpackage

// File: rtl/core/eabv_ctrl.sv
// Valid bits and per-stage load enables of the basis pipeline.
// Depends on eabv_pkg for the stage count.
`timescale 1ns / 1ps

module eabv_ctrl import eabv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIPE_STAGES-1:0] stage_en
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;

    // A stage may load when the output is taken or any stage at or after it is empty.
    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            stage_en[k] = m_ready || (((~valid_reg) >> k) != '0);
        end
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[PIPE_STAGES-1];

endmodule

// File: rtl/core/eabv_sine.sv
// Eleven-stage sine pipeline: angle reduction, fold, radian conversion, odd polynomial.
// Depends on eabv_pkg for constants, sine_t and mul_q30.
`timescale 1ns / 1ps

module eabv_sine import eabv_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter bit IS_COS          = 1'b0
) (
    input  logic                      aclk,
    input  logic [SINE_STAGES-1:0]    stage_en,
    input  logic signed [ANGLE_W-1:0] angle,
    output sine_t                     sine
);

    localparam int FULL    = 360 << ANGLE_FRAC_BITS;
    localparam int HALF    = 180 << ANGLE_FRAC_BITS;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int PHASE   = IS_COS ? QUARTER : 0;
    localparam int IN_MAG  = 1 << (ANGLE_W - 1);
    localparam int OFFSET  = FULL * ((IN_MAG + FULL - 1) / FULL);
    localparam int U_MAX   = IN_MAG - 1 + PHASE + OFFSET;
    localparam int U_W     = $clog2(U_MAX + 1);
    localparam int RECIP   = int'((longint'(1) << U_W) / FULL);
    localparam int RC_W    = $clog2(RECIP + 1);
    localparam int Q_W     = $clog2(U_MAX / FULL + 1);
    localparam int F_W     = $clog2(FULL + 1);
    localparam int R_W     = $clog2(2 * FULL);
    localparam int MAG_W   = $clog2(QUARTER + 1);
    localparam int RAD_SH  = 10 + ANGLE_FRAC_BITS;
    localparam int SUM_W   = MAG_W + D2R_W + 1;
    localparam int T1_W    = 24;
    localparam int T2_W    = 28;
    localparam int T3_W    = 31;

    localparam logic [D2R_HI_W-1:0] D2R_HI   = D2R_Q40[D2R_W-1:D2R_LO_W];
    localparam logic [D2R_LO_W-1:0] D2R_LO   = D2R_Q40[D2R_LO_W-1:0];
    localparam logic [SUM_W-1:0]    RAD_HALF = SUM_W'(1) << (RAD_SH - 1);

    logic [U_W-1:0]              u_reg, u2_reg, u_next;
    logic [Q_W-1:0]              q_reg, q_next;
    logic [R_W-1:0]              r0_reg, r0_next;
    logic [MAG_W-1:0]            mag_reg, mag_next;
    logic [MAG_W+D2R_HI_W-1:0]   pph_reg;
    logic [MAG_W+D2R_LO_W-1:0]   ppl_reg;
    logic [SINE_MAG_W-1:0]       x_reg [5:9];
    logic [SINE_MAG_W-1:0]       x_next;
    logic [31:0]                 x2_reg [6:8];
    logic [31:0]                 x2_next;
    logic [T1_W-1:0]             t1_reg, t1_next;
    logic [T2_W-1:0]             t2_reg, t2_next;
    logic [T3_W-1:0]             t3_reg, t3_next;
    logic [SINE_MAG_W-1:0]       t_reg, t_next;
    logic                        neg_reg [3:10];
    logic                        neg_next;

    logic [U_W+RC_W-1:0]         qprod;
    logic [Q_W+F_W-1:0]          qfull;
    logic [R_W-1:0]              r;
    logic [SUM_W-1:0]            rad_sum;
    logic [33:0]                 m7, m8, m9, m10, m11;

    always_comb begin
        u_next  = U_W'(int'(angle) + PHASE + OFFSET);
        qprod   = (U_W + RC_W)'(u_reg) * (U_W + RC_W)'(RECIP);
        q_next  = qprod[U_W +: Q_W];
        qfull   = (Q_W + F_W)'(q_reg) * (Q_W + F_W)'(FULL);
        r0_next = R_W'(u2_reg - U_W'(qfull));

        r = (r0_reg >= R_W'(FULL)) ? r0_reg - R_W'(FULL) : r0_reg;
        priority if (r <= R_W'(QUARTER)) begin
            neg_next = 1'b0;
            mag_next = MAG_W'(r);
        end else if (r < R_W'(3 * QUARTER)) begin
            if (r > R_W'(HALF)) begin
                neg_next = 1'b1;
                mag_next = MAG_W'(r - R_W'(HALF));
            end else begin
                neg_next = 1'b0;
                mag_next = MAG_W'(R_W'(HALF) - r);
            end
        end else begin
            neg_next = 1'b1;
            mag_next = MAG_W'(R_W'(FULL) - r);
        end

        rad_sum = SUM_W'({pph_reg, {D2R_LO_W{1'b0}}}) + SUM_W'(ppl_reg) + RAD_HALF;
        x_next  = rad_sum[RAD_SH +: SINE_MAG_W];

        m7      = mul_q30(32'(x_reg[5]), 32'(x_reg[5]));
        x2_next = m7[31:0];
        m8      = mul_q30(x2_reg[6], COEF7_Q30);
        t1_next = T1_W'(34'(COEF5_Q30) - m8);
        m9      = mul_q30(x2_reg[7], 32'(t1_reg));
        t2_next = T2_W'(34'(COEF3_Q30) - m9);
        m10     = mul_q30(x2_reg[8], 32'(t2_reg));
        t3_next = T3_W'(34'(ONE_Q30) - m10);
        m11     = mul_q30(32'(x_reg[9]), 32'(t3_reg));
        t_next  = SINE_MAG_W'(m11);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            u_reg <= u_next;
        end
        if (stage_en[1]) begin
            q_reg  <= q_next;
            u2_reg <= u_reg;
        end
        if (stage_en[2]) begin
            r0_reg <= r0_next;
        end
        if (stage_en[3]) begin
            mag_reg    <= mag_next;
            neg_reg[3] <= neg_next;
        end
        if (stage_en[4]) begin
            pph_reg <= (MAG_W + D2R_HI_W)'(mag_reg) * (MAG_W + D2R_HI_W)'(D2R_HI);
            ppl_reg <= (MAG_W + D2R_LO_W)'(mag_reg) * (MAG_W + D2R_LO_W)'(D2R_LO);
        end
        if (stage_en[5]) begin
            x_reg[5] <= x_next;
        end
        if (stage_en[6]) begin
            x2_reg[6] <= x2_next;
            x_reg[6]  <= x_reg[5];
        end
        if (stage_en[7]) begin
            t1_reg    <= t1_next;
            x2_reg[7] <= x2_reg[6];
            x_reg[7]  <= x_reg[6];
        end
        if (stage_en[8]) begin
            t2_reg    <= t2_next;
            x2_reg[8] <= x2_reg[7];
            x_reg[8]  <= x_reg[7];
        end
        if (stage_en[9]) begin
            t3_reg   <= t3_next;
            x_reg[9] <= x_reg[8];
        end
        if (stage_en[10]) begin
            t_reg <= t_next;
        end
        for (int k = 4; k <= 10; k++) begin
            if (stage_en[k]) begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign sine.neg = neg_reg[10];
    assign sine.mag = t_reg;

endmodule

// File: rtl/core/eabv_out.sv
// Output stages: products of the four sines, rounding half away from zero, clamping.
// Depends on eabv_pkg for sine_t and the Q30 format.
`timescale 1ns / 1ps

module eabv_out import eabv_pkg::*; #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic [OUT_STAGES-1:0]         stage_en,
    input  sine_t                         sp,
    input  sine_t                         cp,
    input  sine_t                         sy,
    input  sine_t                         cy,
    output logic signed [OUT_FRAC_BITS+1:0] forward_x,
    output logic signed [OUT_FRAC_BITS+1:0] forward_y,
    output logic signed [OUT_FRAC_BITS+1:0] forward_z,
    output logic signed [OUT_FRAC_BITS+1:0] right_x,
    output logic signed [OUT_FRAC_BITS+1:0] right_y,
    output logic signed [OUT_FRAC_BITS+1:0] up_x,
    output logic signed [OUT_FRAC_BITS+1:0] up_y,
    output logic signed [OUT_FRAC_BITS+1:0] up_z
);

    localparam int OUT_W  = OUT_FRAC_BITS + 2;
    localparam int RND_W  = OUT_FRAC_BITS + 3;
    localparam int PROD_W = 2 * SINE_MAG_W;
    localparam int PSH    = 2 * Q_FRAC - OUT_FRAC_BITS;
    localparam int SSH    = Q_FRAC - OUT_FRAC_BITS;

    localparam logic [PROD_W+1:0]     P_HALF  = (PROD_W + 2)'(1) << PSH;
    localparam logic [SINE_MAG_W+1:0] S_HALF  = (SINE_MAG_W + 2)'(1) << SSH;
    localparam logic [RND_W-1:0]      ONE_OUT = RND_W'(1) << OUT_FRAC_BITS;

    function automatic logic [RND_W-1:0] round_prod(input logic [PROD_W-1:0] p);
        logic [PROD_W+1:0] ext;
        ext = {1'b0, p, 1'b0} + P_HALF;
        return ext[PROD_W+1:PSH+1];
    endfunction

    function automatic logic [RND_W-1:0] round_single(input logic [SINE_MAG_W-1:0] m);
        logic [SINE_MAG_W+1:0] ext;
        ext = {1'b0, m, 1'b0} + S_HALF;
        return RND_W'(ext[SINE_MAG_W+1:SSH+1]);
    endfunction

    function automatic logic [OUT_W-1:0] sat_sign(input logic [RND_W-1:0] mag, input logic neg);
        logic [OUT_W-1:0] m;
        m = (mag > ONE_OUT) ? OUT_W'(ONE_OUT) : OUT_W'(mag);
        return neg ? -m : m;
    endfunction

    logic [PROD_W-1:0] pcc_reg, pcs_reg, psc_reg, pss_reg;
    sine_t             sp_reg, cp_reg, sy_reg, cy_reg;

    logic [OUT_W-1:0]  fx_next, fy_next, fz_next, rx_next, ry_next, ux_next, uy_next, uz_next;
    logic [OUT_W-1:0]  fx_reg, fy_reg, fz_reg, rx_reg, ry_reg, ux_reg, uy_reg, uz_reg;

    always_comb begin
        fx_next = sat_sign(round_prod(pcc_reg), cp_reg.neg ^ cy_reg.neg);
        fy_next = sat_sign(round_prod(pcs_reg), cp_reg.neg ^ sy_reg.neg);
        fz_next = sat_sign(round_single(sp_reg.mag), sp_reg.neg);
        rx_next = sat_sign(round_single(sy_reg.mag), sy_reg.neg);
        ry_next = sat_sign(round_single(cy_reg.mag), !cy_reg.neg);
        ux_next = sat_sign(round_prod(psc_reg), !(sp_reg.neg ^ cy_reg.neg));
        uy_next = sat_sign(round_prod(pss_reg), !(sp_reg.neg ^ sy_reg.neg));
        uz_next = sat_sign(round_single(cp_reg.mag), cp_reg.neg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pcc_reg <= PROD_W'(cp.mag) * PROD_W'(cy.mag);
            pcs_reg <= PROD_W'(cp.mag) * PROD_W'(sy.mag);
            psc_reg <= PROD_W'(sp.mag) * PROD_W'(cy.mag);
            pss_reg <= PROD_W'(sp.mag) * PROD_W'(sy.mag);
            sp_reg  <= sp;
            cp_reg  <= cp;
            sy_reg  <= sy;
            cy_reg  <= cy;
        end
        if (stage_en[1]) begin
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            fz_reg <= fz_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            uz_reg <= uz_next;
        end
    end

    assign forward_x = fx_reg;
    assign forward_y = fy_reg;
    assign forward_z = fz_reg;
    assign right_x   = rx_reg;
    assign right_y   = ry_reg;
    assign up_x      = ux_reg;
    assign up_y      = uy_reg;
    assign up_z      = uz_reg;

endmodule

// File: rtl/core/euler_angles_to_basis_vectors.sv
// Top level: pitch and yaw in fixed-point degrees to forward, right and up unit vectors.
// Depends on eabv_pkg, eabv_ctrl, eabv_sine and eabv_out.
`timescale 1ns / 1ps

// The input channel (s_valid, s_ready) carries one pitch and one yaw angle per transaction,
// signed degrees with ANGLE_FRAC_BITS fraction bits. The result channel (m_valid, m_ready)
// returns one transaction per input: eight vector components, signed, with OUT_FRAC_BITS
// fraction bits and clamped to plus or minus one.
// Each angle feeds two sine pipelines, one for the sine and one for the cosine, each
// eleven register stages long; two more stages form the products and the rounded outputs.
// A transaction moves through the sine stages and then the output stages; m_valid shows
// its result in the last stage. Throughput is one transaction per cycle while m_ready
// is high: every stage holds one transaction, and every multiplier has a register
// behind it, so the thirteen-stage pipeline sets the figure.
// Reset clears all valid bits; no result is presented until a new transaction arrives.
// When m_ready is low the last stage holds its result; earlier stages keep moving into
// any empty stage behind it, and s_ready drops only when all thirteen stages are full.

module euler_angles_to_basis_vectors import eabv_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int OUT_FRAC_BITS   = 14
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [ANGLE_W-1:0]       s_pitch_angle,
    input  logic signed [ANGLE_W-1:0]       s_yaw_angle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [OUT_FRAC_BITS+1:0] m_forward_x,
    output logic signed [OUT_FRAC_BITS+1:0] m_forward_y,
    output logic signed [OUT_FRAC_BITS+1:0] m_forward_z,
    output logic signed [OUT_FRAC_BITS+1:0] m_right_x,
    output logic signed [OUT_FRAC_BITS+1:0] m_right_y,
    output logic signed [OUT_FRAC_BITS+1:0] m_up_x,
    output logic signed [OUT_FRAC_BITS+1:0] m_up_y,
    output logic signed [OUT_FRAC_BITS+1:0] m_up_z
);

    logic [PIPE_STAGES-1:0] stage_en;
    sine_t                  sp, cp, sy, cy;

    eabv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    eabv_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IS_COS(1'b0)) u_sin_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[SINE_STAGES-1:0]),
        .angle    (s_pitch_angle),
        .sine     (sp)
    );

    eabv_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IS_COS(1'b1)) u_cos_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[SINE_STAGES-1:0]),
        .angle    (s_pitch_angle),
        .sine     (cp)
    );

    eabv_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IS_COS(1'b0)) u_sin_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[SINE_STAGES-1:0]),
        .angle    (s_yaw_angle),
        .sine     (sy)
    );

    eabv_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IS_COS(1'b1)) u_cos_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[SINE_STAGES-1:0]),
        .angle    (s_yaw_angle),
        .sine     (cy)
    );

    eabv_out #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_out (
        .aclk      (aclk),
        .stage_en  (stage_en[PIPE_STAGES-1:SINE_STAGES]),
        .sp        (sp),
        .cp        (cp),
        .sy        (sy),
        .cy        (cy),
        .forward_x (m_forward_x),
        .forward_y (m_forward_y),
        .forward_z (m_forward_z),
        .right_x   (m_right_x),
        .right_y   (m_right_y),
        .up_x      (m_up_x),
        .up_y      (m_up_y),
        .up_z      (m_up_z)
    );

endmodule

// File: rtl/core/eabv_checker.sv
// Port-level checks for euler_angles_to_basis_vectors, attached by a bind statement.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module eabv_checker #(
    parameter int OUT_FRAC_BITS = 14
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [OUT_FRAC_BITS+1:0] m_forward_x,
    input logic signed [OUT_FRAC_BITS+1:0] m_forward_y,
    input logic signed [OUT_FRAC_BITS+1:0] m_forward_z,
    input logic signed [OUT_FRAC_BITS+1:0] m_up_x,
    input logic signed [OUT_FRAC_BITS+1:0] m_up_y,
    input logic signed [OUT_FRAC_BITS+1:0] m_up_z
);

    // No result may appear in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An empty output stage means the pipeline can always take a transaction.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage is empty");

    // A zero pitch sine forces zero in both up components that scale it.
    a_sin_pitch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_forward_z == 0 |-> m_up_x == 0 && m_up_y == 0)
        else $error("up vector nonzero with zero pitch sine");

    // A zero pitch cosine forces zero in both forward components that scale it.
    a_cos_pitch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_up_z == 0 |-> m_forward_x == 0 && m_forward_y == 0)
        else $error("forward vector nonzero with zero pitch cosine");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_forward_x) && $stable(m_up_z))
        else $error("result changed while stalled");

endmodule

bind euler_angles_to_basis_vectors eabv_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_checker (.*);

// File: sim/tb_euler_angles_to_basis_vectors.sv
// Self-checking testbench for euler_angles_to_basis_vectors: directed and random angle pairs
// with random input gaps and output stalls, checked against a fixed-point predictor.
// Depends on eabv_pkg and the RTL of euler_angles_to_basis_vectors.
`timescale 1ns / 1ps

module tb_euler_angles_to_basis_vectors;
    import eabv_pkg::*;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int OUT_W           = OUT_FRAC_BITS + 2;
    localparam int NUM_RANDOM      = 800;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_STALL      = 200;
    localparam int STALL_AFTER     = 300;

    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;

    localparam longint unsigned RAD_PER_DEG_Q40 = 64'd19190098069;
    localparam longint unsigned INV6_Q30        = 64'd178956971;
    localparam longint unsigned INV120_Q30      = 64'd8947849;
    localparam longint unsigned INV5040_Q30     = 64'd213044;
    localparam longint unsigned UNITY_Q30       = 64'd1073741824;
    localparam longint          UNITY_OUT       = 64'sd1 << OUT_FRAC_BITS;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [7:0][OUT_W-1:0] basis_vec_t;

    class basis_scoreboard;
        basis_vec_t expected_basis[$];
        int         error_count;
        string      comp_name[8];

        function new();
            comp_name = '{"forward_x", "forward_y", "forward_z", "right_x",
                          "right_y", "up_x", "up_y", "up_z"};
            error_count = 0;
        endfunction

        function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
            return (a * b + (64'd1 << 29)) >> 30;
        endfunction

        function longint round_shift(longint v, int sh);
            longint unsigned mag;
            bit              neg;
            neg = v < 0;
            mag = neg ? -v : v;
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function logic [OUT_W-1:0] to_out(longint v, int sh);
            longint r;
            r = round_shift(v, sh);
            if (r > UNITY_OUT)
                r = UNITY_OUT;
            else if (r < -UNITY_OUT)
                r = -UNITY_OUT;
            return r[OUT_W-1:0];
        endfunction

        // Sine in signed Q30 of an angle in fixed-point degrees.
        function longint sine_of_degrees(int deg);
            int              m;
            bit              neg;
            longint unsigned mag, x, x2, t;
            m = deg % FULL_TURN;
            if (m > HALF_TURN)
                m -= FULL_TURN;
            if (m < -HALF_TURN)
                m += FULL_TURN;
            if (m > QUARTER_TURN)
                m = HALF_TURN - m;
            else if (m < -QUARTER_TURN)
                m = -HALF_TURN - m;
            neg = m < 0;
            mag = neg ? -m : m;
            x  = (mag * RAD_PER_DEG_Q40 + (64'd1 << (9 + ANGLE_FRAC_BITS)))
                 >> (10 + ANGLE_FRAC_BITS);
            x2 = q30_mul(x, x);
            t  = INV120_Q30 - q30_mul(x2, INV5040_Q30);
            t  = INV6_Q30 - q30_mul(x2, t);
            t  = UNITY_Q30 - q30_mul(x2, t);
            t  = q30_mul(x, t);
            return neg ? -longint'(t) : longint'(t);
        endfunction

        function void note_angles(angle_t pitch, angle_t yaw);
            longint     sp, cp, sy, cy;
            basis_vec_t v;
            sp = sine_of_degrees(int'(pitch));
            cp = sine_of_degrees(int'(pitch) + QUARTER_TURN);
            sy = sine_of_degrees(int'(yaw));
            cy = sine_of_degrees(int'(yaw) + QUARTER_TURN);
            v[0] = to_out(cp * cy, 60 - OUT_FRAC_BITS);
            v[1] = to_out(cp * sy, 60 - OUT_FRAC_BITS);
            v[2] = to_out(sp, 30 - OUT_FRAC_BITS);
            v[3] = to_out(sy, 30 - OUT_FRAC_BITS);
            v[4] = to_out(-cy, 30 - OUT_FRAC_BITS);
            v[5] = to_out((-sp) * cy, 60 - OUT_FRAC_BITS);
            v[6] = to_out((-sp) * sy, 60 - OUT_FRAC_BITS);
            v[7] = to_out(cp, 30 - OUT_FRAC_BITS);
            expected_basis.push_back(v);
        endfunction

        function void check_basis(basis_vec_t got);
            basis_vec_t want;
            if (expected_basis.size() == 0) begin
                $error("Result transaction arrived with no expected result pending.");
                error_count++;
                return;
            end
            want = expected_basis.pop_front();
            for (int i = 0; i < 8; i++) begin
                if (got[i] !== want[i]) begin
                    $error("%s: expected %0d, actual %0d", comp_name[i],
                           $signed(want[i]), $signed(got[i]));
                    error_count++;
                end
            end
        endfunction

        function int pending();
            return expected_basis.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    angle_t                  s_pitch_angle = '0;
    angle_t                  s_yaw_angle   = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [OUT_W-1:0] m_forward_x, m_forward_y, m_forward_z;
    logic signed [OUT_W-1:0] m_right_x, m_right_y;
    logic signed [OUT_W-1:0] m_up_x, m_up_y, m_up_z;

    basis_scoreboard sb = new();
    int              accepted_inputs = 0;
    angle_t          pitch_q[$];
    angle_t          yaw_q[$];

    euler_angles_to_basis_vectors #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pitch_angle(s_pitch_angle),
        .s_yaw_angle  (s_yaw_angle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_forward_x  (m_forward_x),
        .m_forward_y  (m_forward_y),
        .m_forward_z  (m_forward_z),
        .m_right_x    (m_right_x),
        .m_right_y    (m_right_y),
        .m_up_x       (m_up_x),
        .m_up_y       (m_up_y),
        .m_up_z       (m_up_z)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_angles(s_pitch_angle, s_yaw_angle);
            accepted_inputs++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_basis({m_up_z, m_up_y, m_up_x, m_right_y, m_right_x,
                            m_forward_z, m_forward_y, m_forward_x});
    end

    function automatic angle_t random_angle();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return angle_t'($urandom);
            4, 5, 6:    return angle_t'(int'($urandom_range(0, 51200)) - 25600);
            default: begin
                k = int'($urandom_range(0, 10)) - 5;
                return angle_t'(k * QUARTER_TURN + int'($urandom_range(0, 6)) - 3);
            end
        endcase
    endfunction

    task automatic add_pair(int pitch, int yaw);
        pitch_q.push_back(angle_t'(pitch));
        yaw_q.push_back(angle_t'(yaw));
    endtask

    task automatic send_angles(angle_t pitch, angle_t yaw);
        s_valid       <= 1'b1;
        s_pitch_angle <= pitch;
        s_yaw_angle   <= yaw;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // The receiver keeps its own stall pattern and, once, holds off long enough for the
    // pipeline to fill up and push back on the sender.
    initial begin
        int cyc;
        int mode;
        bit held_off;
        cyc      = 0;
        mode     = 0;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held_off && accepted_inputs >= STALL_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= (cyc % 4 == 0);
                default: m_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int burst;
        int gap;
        add_pair(0, 0);
        add_pair(QUARTER_TURN, 0);
        add_pair(-QUARTER_TURN, QUARTER_TURN);
        add_pair(HALF_TURN, -HALF_TURN);
        add_pair(-HALF_TURN, HALF_TURN);
        add_pair(32767, -32768);
        add_pair(-32768, 32767);
        add_pair(FULL_TURN, -FULL_TURN);
        add_pair(3 * QUARTER_TURN, -3 * QUARTER_TURN);
        add_pair(QUARTER_TURN - 1, QUARTER_TURN + 1);
        add_pair(-QUARTER_TURN - 1, -QUARTER_TURN + 1);
        add_pair(HALF_TURN - 1, -HALF_TURN - 1);
        add_pair(HALF_TURN + 1, -HALF_TURN + 1);
        add_pair(1, -1);
        add_pair(QUARTER_TURN / 2, -QUARTER_TURN / 2);
        add_pair(-3 * QUARTER_TURN / 2, 3 * QUARTER_TURN / 2);
        add_pair(16'h5555, 16'hAAAA);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            pitch_q.push_back(random_angle());
            yaw_q.push_back(random_angle());
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        burst = 0;
        for (int i = 0; i < pitch_q.size(); i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            send_angles(pitch_q[i], yaw_q[i]);
            burst--;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: euler_angles_to_basis_vectors.f
rtl/core/eabv_pkg.sv
rtl/core/eabv_ctrl.sv
rtl/core/eabv_sine.sv
rtl/core/eabv_out.sv
rtl/core/euler_angles_to_basis_vectors.sv
rtl/core/eabv_checker.sv
sim/tb_euler_angles_to_basis_vectors.sv
